// ----- src/bfra_pkg.sv -----
`default_nettype none

package bfra_pkg;

    localparam int MAX_FREE = 64;
    localparam int MAX_PEND = 64;

    localparam int FIDX_W = (MAX_FREE > 1) ? $clog2(MAX_FREE) : 1;
    localparam int FCNT_W = $clog2(MAX_FREE + 1);
    localparam int PIDX_W = (MAX_PEND > 1) ? $clog2(MAX_PEND) : 1;
    localparam int PCNT_W = $clog2(MAX_PEND + 1);

    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_ALLOC = 3'd1;
    localparam logic [2:0] OP_FREE  = 3'd2;
    localparam logic [2:0] OP_DEFER = 3'd3;
    localparam logic [2:0] OP_FLUSH = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic [31:0] CAP_RESET = 32'd65536;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
    } t_fent;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] len;
        logic [63:0] fence;
    } t_pent;

    typedef enum logic [2:0] {
        FC_HOLD,
        FC_ROT,
        FC_WRITE,
        FC_INSERT,
        FC_REMOVE
    } t_fop;

    typedef struct packed {
        t_fop              op;
        logic [FIDX_W-1:0] idx;
        t_fent             data;
    } t_fcmd;

    typedef enum logic [1:0] {
        PC_HOLD,
        PC_POP,
        PC_POPPUSH,
        PC_WRITE
    } t_pop;

    typedef struct packed {
        t_pop              op;
        logic [PIDX_W-1:0] idx;
        t_pent             data;
    } t_pcmd;

    // cut count so the range ends at or below 2^32
    function automatic logic [31:0] clip_count(input logic [31:0] base,
                                               input logic [31:0] count);
        logic [32:0] s;
        s = {1'b0, base} + {1'b0, count};
        if (s[32] && (s[31:0] != 32'd0)) begin
            return (~base) + 32'd1;
        end
        return count;
    endfunction

endpackage

`default_nettype wire

// ----- src/bfra_if.sv -----
`default_nettype none

interface bfra_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [31:0] range_base;
    logic [31:0] range_count;
    logic [63:0] fence_value;

    modport source(output valid, opcode, range_base, range_count, fence_value, input ready);
    modport sink(input valid, opcode, range_base, range_count, fence_value, output ready);
endinterface

interface bfra_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] alloc_base;
    logic [31:0] allocated_total;

    modport source(output valid, status, alloc_base, allocated_total, input ready);
    modport sink(input valid, status, alloc_base, allocated_total, output ready);
endinterface

`default_nettype wire

// ----- src/bfra_free_cell.sv -----
`default_nettype none

module bfra_free_cell (
    input  wire logic                          i_clk,
    input  wire logic [bfra_pkg::FIDX_W-1:0]   i_idx,
    input  wire bfra_pkg::t_fcmd               i_cmd,
    input  wire bfra_pkg::t_fent               i_left,
    input  wire bfra_pkg::t_fent               i_right,
    output bfra_pkg::t_fent                    o_ent
);

    bfra_pkg::t_fent r_ent;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bfra_pkg::FC_ROT: begin
                r_ent <= i_right;
            end
            bfra_pkg::FC_WRITE: begin
                if (i_idx == i_cmd.idx) begin
                    r_ent <= i_cmd.data;
                end
            end
            bfra_pkg::FC_INSERT: begin
                if (i_idx == i_cmd.idx) begin
                    r_ent <= i_cmd.data;
                end else if (i_idx > i_cmd.idx) begin
                    r_ent <= i_left;
                end
            end
            bfra_pkg::FC_REMOVE: begin
                if (i_idx >= i_cmd.idx) begin
                    r_ent <= i_right;
                end
            end
            default: begin
                r_ent <= r_ent;
            end
        endcase
    end

    assign o_ent = r_ent;

endmodule

`default_nettype wire

// ----- src/bfra_pend_cell.sv -----
`default_nettype none

module bfra_pend_cell (
    input  wire logic                          i_clk,
    input  wire logic [bfra_pkg::PIDX_W-1:0]   i_idx,
    input  wire bfra_pkg::t_pcmd               i_cmd,
    input  wire bfra_pkg::t_pent               i_right,
    output bfra_pkg::t_pent                    o_ent
);

    bfra_pkg::t_pent r_ent;

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bfra_pkg::PC_POP: begin
                r_ent <= i_right;
            end
            bfra_pkg::PC_POPPUSH: begin
                // head leaves, kept entry re-enters at the tail
                if (i_idx == i_cmd.idx) begin
                    r_ent <= i_cmd.data;
                end else begin
                    r_ent <= i_right;
                end
            end
            bfra_pkg::PC_WRITE: begin
                if (i_idx == i_cmd.idx) begin
                    r_ent <= i_cmd.data;
                end
            end
            default: begin
                r_ent <= r_ent;
            end
        endcase
    end

    assign o_ent = r_ent;

endmodule

`default_nettype wire

// ----- src/best_fit_range_allocator_core.sv -----
// Best-fit range allocator over a slot heap (slot 0 reserved).
// Request channel i_req: opcode, range_base, range_count, fence_value; one
// transfer when valid and ready are high. Response channel o_rsp: status,
// alloc_base, allocated_total; exactly one response per request, in order.
// i_cfg_we/i_cfg_wdata write heap_capacity, used by the next init.
// The free table is a ring of 64 cells; a scan rotates it once through the
// head cell, one entry per cycle, and updates are applied in place after.
// The deferred-free queue is a second row of cells, popped at its head.
// Steps from request transfer to response valid:
//   init, defer_free, ignored requests: no scan, straight to respond
//   alloc: scan, apply, respond
//   free: scan, apply, remove when the range joins two neighbors, respond
//   flush: each queued entry is taken from the head; a ready one is freed
//   like a free, one not ready goes back to the tail; then respond.
// One request is in work at a time; ready is high only when idle. A finished
// response moves to the output register and the block goes idle, so the next
// request is taken while the receiver stalls; its response then waits until
// the output register is free.
// Synchronous reset sets capacity to 65536, empties both tables, clears the
// allocated total and drops any pending response. No clearing pass is needed.
`default_nettype none

module best_fit_range_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bfra_req_if.sink         i_req,
    bfra_rsp_if.source       o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata
);

    localparam int FIDX_W = bfra_pkg::FIDX_W;
    localparam int FCNT_W = bfra_pkg::FCNT_W;
    localparam int PIDX_W = bfra_pkg::PIDX_W;
    localparam int PCNT_W = bfra_pkg::PCNT_W;
    localparam int NF     = bfra_pkg::MAX_FREE;
    localparam int NP     = bfra_pkg::MAX_PEND;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_ASCAN  = 8'b0000_0010,
        S_AAPPLY = 8'b0000_0100,
        S_RSCAN  = 8'b0000_1000,
        S_RAPPLY = 8'b0001_0000,
        S_RREM   = 8'b0010_0000,
        S_FHEAD  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state              r_state;
    logic [31:0]         r_cap;
    logic [FCNT_W-1:0]   r_n;
    logic [PCNT_W-1:0]   r_pe;
    logic [31:0]         r_slots;
    logic [FIDX_W-1:0]   r_j;
    logic [31:0]         r_base;
    logic [31:0]         r_cnt;
    logic [63:0]         r_fence;
    logic                r_found;
    logic [FCNT_W-1:0]   r_pos;
    bfra_pkg::t_fent     r_pred;
    bfra_pkg::t_fent     r_succ;
    logic [PCNT_W-1:0]   r_fl_left;
    logic                r_in_flush;
    logic [1:0]          r_status;
    logic [31:0]         r_granted;
    logic                r_o_valid;
    logic [1:0]          r_o_status;
    logic [31:0]         r_o_base;
    logic [31:0]         r_o_total;

    bfra_pkg::t_fent     w_fent [NF];
    bfra_pkg::t_pent     w_pent [NP];
    bfra_pkg::t_fcmd     w_fcmd;
    bfra_pkg::t_pcmd     w_pcmd;

    logic                w_accept;
    logic                w_ign;
    logic [31:0]         w_sbase;
    logic [31:0]         w_scnt;
    logic                w_pfull;
    logic                w_jvalid;
    bfra_pkg::t_fent     w_head;
    bfra_pkg::t_pent     w_phead;
    logic                w_pready;
    logic [FCNT_W-1:0]   w_pos;
    logic [32:0]         w_pred_end;
    logic [32:0]         w_bend;
    logic                w_mp;
    logic                w_ms;
    logic                w_tfull;
    logic [31:0]         w_slots_sub;
    logic                w_out_free;

    // ---------------- cell rows ----------------
    for (genvar gi = 0; gi < NF; gi++) begin : g_free
        bfra_free_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (FIDX_W'(gi)),
            .i_cmd   (w_fcmd),
            .i_left  (w_fent[(gi + NF - 1) % NF]),
            .i_right (w_fent[(gi + 1) % NF]),
            .o_ent   (w_fent[gi])
        );
    end

    for (genvar gp = 0; gp < NP; gp++) begin : g_pend
        bfra_pend_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (PIDX_W'(gp)),
            .i_cmd   (w_pcmd),
            .i_right (w_pent[(gp + 1) % NP]),
            .o_ent   (w_pent[gp])
        );
    end

    // ---------------- decode ----------------
    assign w_accept = i_req.valid && i_req.ready;
    assign w_ign    = (i_req.range_count == 32'd0) || (i_req.range_base == '1) ||
                      ((i_req.range_base == 32'd0) && (i_req.range_count == 32'd1));
    // slot 0 is stripped from the front of the range
    assign w_sbase  = (i_req.range_base == 32'd0) ? 32'd1 : i_req.range_base;
    assign w_scnt   = (i_req.range_base == 32'd0) ? (i_req.range_count - 32'd1)
                                                  : i_req.range_count;
    assign w_pfull  = (r_pe >= PCNT_W'(NP));

    assign w_head   = w_fent[0];
    assign w_phead  = w_pent[0];
    assign w_pready = (w_phead.fence <= r_fence);
    assign w_jvalid = (FCNT_W'(r_j) < r_n);

    assign w_pos      = r_found ? r_pos : r_n;
    assign w_pred_end = {1'b0, r_pred.start} + {1'b0, r_pred.len};
    assign w_bend     = {1'b0, r_base} + {1'b0, r_cnt};
    assign w_mp       = (w_pos != '0) && (w_pred_end == {1'b0, r_base});
    assign w_ms       = r_found && ({1'b0, r_succ.start} == w_bend);
    assign w_tfull    = !w_mp && !w_ms && (r_n >= FCNT_W'(NF));
    assign w_slots_sub = (r_slots >= r_cnt) ? (r_slots - r_cnt) : 32'd0;
    assign w_out_free = !r_o_valid || o_rsp.ready;

    // ---------------- cell commands ----------------
    always_comb begin
        w_fcmd.op   = bfra_pkg::FC_HOLD;
        w_fcmd.idx  = '0;
        w_fcmd.data = '0;
        w_pcmd.op   = bfra_pkg::PC_HOLD;
        w_pcmd.idx  = '0;
        w_pcmd.data = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_req.opcode == bfra_pkg::OP_INIT)) begin
                    w_fcmd.op         = bfra_pkg::FC_WRITE;
                    w_fcmd.data.start = 32'd1;
                    w_fcmd.data.len   = r_cap - 32'd1;
                end
                if (w_accept && (i_req.opcode == bfra_pkg::OP_DEFER) && !w_ign &&
                    !w_pfull) begin
                    w_pcmd.op         = bfra_pkg::PC_WRITE;
                    w_pcmd.idx        = r_pe[PIDX_W-1:0];
                    w_pcmd.data.start = w_sbase;
                    w_pcmd.data.len   = w_scnt;
                    w_pcmd.data.fence = i_req.fence_value;
                end
            end
            S_ASCAN, S_RSCAN: begin
                w_fcmd.op = bfra_pkg::FC_ROT;
            end
            S_AAPPLY: begin
                if (r_found) begin
                    w_fcmd.idx = r_pos[FIDX_W-1:0];
                    if (r_succ.len == r_cnt) begin
                        w_fcmd.op = bfra_pkg::FC_REMOVE;
                    end else begin
                        w_fcmd.op         = bfra_pkg::FC_WRITE;
                        w_fcmd.data.start = r_succ.start + r_cnt;
                        w_fcmd.data.len   = r_succ.len - r_cnt;
                    end
                end
            end
            S_RAPPLY: begin
                if (!w_tfull) begin
                    if (w_mp) begin
                        w_fcmd.op         = bfra_pkg::FC_WRITE;
                        w_fcmd.idx        = FIDX_W'(w_pos - FCNT_W'(1));
                        w_fcmd.data.start = r_pred.start;
                        w_fcmd.data.len   = w_ms ? (r_pred.len + r_cnt + r_succ.len)
                                                 : (r_pred.len + r_cnt);
                    end else if (w_ms) begin
                        w_fcmd.op         = bfra_pkg::FC_WRITE;
                        w_fcmd.idx        = w_pos[FIDX_W-1:0];
                        w_fcmd.data.start = r_base;
                        w_fcmd.data.len   = r_succ.len + r_cnt;
                    end else begin
                        w_fcmd.op         = bfra_pkg::FC_INSERT;
                        w_fcmd.idx        = w_pos[FIDX_W-1:0];
                        w_fcmd.data.start = r_base;
                        w_fcmd.data.len   = r_cnt;
                    end
                end
            end
            S_RREM: begin
                w_fcmd.op  = bfra_pkg::FC_REMOVE;
                w_fcmd.idx = r_pos[FIDX_W-1:0];
            end
            S_FHEAD: begin
                if (r_fl_left != '0) begin
                    if (w_pready) begin
                        w_pcmd.op = bfra_pkg::PC_POP;
                    end else begin
                        w_pcmd.op   = bfra_pkg::PC_POPPUSH;
                        w_pcmd.idx  = PIDX_W'(r_pe - PCNT_W'(1));
                        w_pcmd.data = w_phead;
                    end
                end
            end
            default: begin
                w_fcmd.op = bfra_pkg::FC_HOLD;
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cap      <= bfra_pkg::CAP_RESET;
            r_n        <= '0;
            r_pe       <= '0;
            r_slots    <= 32'd0;
            r_in_flush <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            // S_DONE reloads the output register itself
            if (r_o_valid && o_rsp.ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_granted <= '1;
                        r_found   <= 1'b0;
                        r_j       <= '0;
                        r_fence   <= i_req.fence_value;
                        case (i_req.opcode)
                            bfra_pkg::OP_INIT: begin
                                r_n      <= (r_cap > 32'd1) ? FCNT_W'(1) : '0;
                                r_pe     <= '0;
                                r_slots  <= 32'd0;
                                r_status <= bfra_pkg::ST_DONE;
                                r_state  <= S_DONE;
                            end
                            bfra_pkg::OP_ALLOC: begin
                                r_cnt    <= i_req.range_count;
                                r_status <= bfra_pkg::ST_IGNORED;
                                r_state  <= (i_req.range_count != 32'd0) ? S_ASCAN : S_DONE;
                            end
                            bfra_pkg::OP_FREE: begin
                                r_base   <= w_sbase;
                                r_cnt    <= bfra_pkg::clip_count(w_sbase, w_scnt);
                                r_status <= w_ign ? bfra_pkg::ST_IGNORED : bfra_pkg::ST_DONE;
                                r_state  <= w_ign ? S_DONE : S_RSCAN;
                            end
                            bfra_pkg::OP_DEFER: begin
                                r_state <= S_DONE;
                                if (w_ign) begin
                                    r_status <= bfra_pkg::ST_IGNORED;
                                end else if (w_pfull) begin
                                    r_status <= bfra_pkg::ST_FULL;
                                end else begin
                                    r_status <= bfra_pkg::ST_DONE;
                                    r_pe     <= r_pe + PCNT_W'(1);
                                end
                            end
                            bfra_pkg::OP_FLUSH: begin
                                r_status   <= bfra_pkg::ST_DONE;
                                r_fl_left  <= r_pe;
                                r_in_flush <= 1'b1;
                                r_state    <= S_FHEAD;
                            end
                            default: begin
                                r_status <= bfra_pkg::ST_IGNORED;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_ASCAN: begin
                    // smallest fitting length; strict compare keeps the lowest base
                    if (w_jvalid && (w_head.len >= r_cnt) &&
                        (!r_found || (w_head.len < r_succ.len))) begin
                        r_found <= 1'b1;
                        r_pos   <= FCNT_W'(r_j);
                        r_succ  <= w_head;
                    end
                    r_j <= r_j + FIDX_W'(1);
                    if (r_j == FIDX_W'(NF - 1)) begin
                        r_state <= S_AAPPLY;
                    end
                end
                S_AAPPLY: begin
                    if (r_found) begin
                        r_granted <= r_succ.start;
                        r_status  <= bfra_pkg::ST_DONE;
                        r_slots   <= ((32'hFFFF_FFFF - r_slots) >= r_cnt) ?
                                     (r_slots + r_cnt) : 32'hFFFF_FFFF;
                        if (r_succ.len == r_cnt) begin
                            r_n <= r_n - FCNT_W'(1);
                        end
                    end else begin
                        r_status <= bfra_pkg::ST_NOFIT;
                    end
                    r_state <= S_DONE;
                end
                S_RSCAN: begin
                    if (w_jvalid && !r_found) begin
                        if (w_head.start > r_base) begin
                            r_found <= 1'b1;
                            r_pos   <= FCNT_W'(r_j);
                            r_succ  <= w_head;
                        end else begin
                            r_pred <= w_head;
                        end
                    end
                    r_j <= r_j + FIDX_W'(1);
                    if (r_j == FIDX_W'(NF - 1)) begin
                        r_state <= S_RAPPLY;
                    end
                end
                S_RAPPLY: begin
                    r_pos <= w_pos;
                    if (w_tfull) begin
                        r_status <= bfra_pkg::ST_FULL;
                    end else begin
                        r_slots <= w_slots_sub;
                        if (!w_mp && !w_ms) begin
                            r_n <= r_n + FCNT_W'(1);
                        end
                    end
                    if (!w_tfull && w_mp && w_ms) begin
                        r_state <= S_RREM;
                    end else if (r_in_flush) begin
                        r_state <= S_FHEAD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_RREM: begin
                    r_n     <= r_n - FCNT_W'(1);
                    r_state <= r_in_flush ? S_FHEAD : S_DONE;
                end
                S_FHEAD: begin
                    if (r_fl_left == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_fl_left <= r_fl_left - PCNT_W'(1);
                        if (w_pready) begin
                            r_pe    <= r_pe - PCNT_W'(1);
                            r_base  <= w_phead.start;
                            r_cnt   <= bfra_pkg::clip_count(w_phead.start, w_phead.len);
                            r_found <= 1'b0;
                            r_j     <= '0;
                            r_state <= S_RSCAN;
                        end
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_status;
                        r_o_base   <= r_granted;
                        r_o_total  <= r_slots;
                        r_in_flush <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.alloc_base      = r_o_base;
    assign o_rsp.allocated_total = r_o_total;

endmodule

`default_nettype wire

// ----- src/bfra_checker.sv -----
`default_nettype none

module bfra_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_status,
    input wire logic [31:0] i_alloc_base,
    input wire logic [31:0] i_total
);

    // one request in work: ready drops right after a transfer
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while busy");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_status) && $stable(i_alloc_base) && $stable(i_total)))
        else $error("stalled response changed");

    // only a successful request may carry a granted base
    a_base_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != bfra_pkg::ST_DONE)) |-> (i_alloc_base == '1))
        else $error("base granted on failed request");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in_ready && !i_out_valid))
        else $error("not idle after reset");

endmodule

bind best_fit_range_allocator_core bfra_checker u_bfra_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_alloc_base (o_rsp.alloc_base),
    .i_total      (o_rsp.allocated_total)
);

`default_nettype wire
